FILE: rtl/core/arp_pkg.sv
// Shared types and constants for the axis rate profiler.
`default_nettype none

package arp_pkg;

  localparam int REG_W  = 31;
  localparam int RATE_W = 32;

  localparam logic [REG_W-1:0] ACCEL_RST   = 31'd5898240;
  localparam logic [REG_W-1:0] MAX_RATE_RST = 31'd5898240;
  localparam logic [REG_W-1:0] FALLOFF_RST = 31'd0;

  typedef enum logic [1:0] {
    CFG_ACCEL    = 2'd0,
    CFG_MAX_RATE = 2'd1,
    CFG_FALLOFF  = 2'd2
  } cfg_idx_t;

  // Carried alongside the deceleration distance division.
  typedef struct packed {
    logic              mode;
    logic [31:0]       n0;
    logic [31:0]       r;
    logic              epos;
    logic              ezero;
    logic [31:0]       ue;
    logic [62:0]       p_re;
    logic [30:0]       full;
    logic [62:0]       sue;
    logic              fall;
    logic              a_zero;
  } side1_t;

  // Carried alongside the ratio division.
  typedef struct packed {
    logic              mode;
    logic [31:0]       n0;
    logic [31:0]       r;
    logic              epos;
    logic              ezero;
    logic              near;
    logic              fall;
    logic [30:0]       full;
  } side2_t;

endpackage

`default_nettype wire

FILE: rtl/core/arp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module arp_div_pipe #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              vld_r  [QUO_W];
  logic [CW-1:0]     rem_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  logic              vld_i  [QUO_W];
  logic [CW-1:0]     rem_i  [QUO_W];
  logic [DEN_W-1:0]  den_i  [QUO_W];
  logic [QUO_W-1:0]  quo_i  [QUO_W];
  logic [SIDE_W-1:0] side_i [QUO_W];

  logic [CW-1:0]     rem_nxt [QUO_W];
  logic [QUO_W-1:0]  quo_nxt [QUO_W];

  always_comb begin
    logic [CW-1:0] dsh;
    logic          ge;
    vld_i[0]  = in_vld;
    rem_i[0]  = CW'(in_num);
    den_i[0]  = in_den;
    quo_i[0]  = '0;
    side_i[0] = in_side;
    for (int i = 1; i < QUO_W; i++) begin
      vld_i[i]  = vld_r[i-1];
      rem_i[i]  = rem_r[i-1];
      den_i[i]  = den_r[i-1];
      quo_i[i]  = quo_r[i-1];
      side_i[i] = side_r[i-1];
    end
    for (int i = 0; i < QUO_W; i++) begin
      // stage i decides quotient bit QUO_W-1-i
      dsh        = CW'(den_i[i]) << (QUO_W - 1 - i);
      ge         = (rem_i[i] >= dsh);
      rem_nxt[i] = ge ? rem_i[i] - dsh : rem_i[i];
      quo_nxt[i] = quo_i[i] | (QUO_W'(ge) << (QUO_W - 1 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_i;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/axis_rate_profiler.sv
// Top level of the per-axis angular rate profiler.
// The block takes one transaction in every clock cycle (busy stays low) and
// returns exactly one new_rate per transaction, in order. A transaction
// passes through the deceleration distance division (62 stages, one quotient
// bit each) and then the ratio division (32 stages), plus seven stages of
// magnitude, multiply, slew and output logic. out_strobe lasts one cycle and
// cannot be held off. Write configuration only while no transaction is in
// flight.
`default_nettype none

module axis_rate_profiler import arp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_mode,
  input  wire logic signed [31:0] in_current_rate,
  input  wire logic signed [15:0] in_stick,
  input  wire logic signed [31:0] in_angle_error,
  input  wire logic [15:0]       in_step_time,
  output logic                   out_strobe,
  output logic signed [31:0]     out_new_rate,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data
);

  // configuration
  logic [REG_W-1:0] accel_r, max_rate_r, falloff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r    <= ACCEL_RST;
      max_rate_r <= MAX_RATE_RST;
      falloff_r  <= FALLOFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACCEL:    accel_r    <= cfg_data;
        CFG_MAX_RATE: max_rate_r <= cfg_data;
        CFG_FALLOFF:  falloff_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // the pipeline takes a transaction every cycle
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: capture
  logic               v1_r, mode1_r;
  logic signed [31:0] r1_r, e1_r;
  logic signed [15:0] stk1_r;
  logic [15:0]        step1_r;

  // stage 2: magnitudes
  logic               v2_r, mode2_r, epos2_r, ezero2_r;
  logic signed [31:0] r2_r;
  logic signed [15:0] stk2_r;
  logic [15:0]        mstk2_r, step2_r;
  logic [31:0]        mr2_r, ue2_r;

  // stage 3: products
  logic               v3_r, mode3_r, epos3_r, ezero3_r;
  logic signed [31:0] r3_r;
  logic [15:0]        mstk3_r;
  logic [31:0]        ue3_r;
  logic [63:0]        p_rr3_r;
  logic [62:0]        p_re3_r;
  logic [46:0]        p_as3_r;
  logic signed [46:0] p_t3_r;

  // stage 4: slews and target
  logic               v4_r, mode4_r, epos4_r, ezero4_r, fall4_r;
  logic signed [31:0] r4_r;
  logic [31:0]        ue4_r, opp4_r;
  logic [63:0]        p_rr4_r;
  logic [62:0]        p_re4_r, sue4_r;
  logic [30:0]        full4_r;
  logic signed [32:0] t4_r;

  // stage 5: stick result, division operands
  logic               v5_r;
  logic [63:0]        p_rr5_r;
  side1_t             sd1_r;
  logic signed [31:0] n0_nxt;

  logic signed [31:0] lim_s;
  logic [63:0]        p_rr_full, p_re_full;
  logic [62:0]        opp_full;

  assign lim_s = {1'b0, max_rate_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign p_rr_full = {32'b0, mr2_r} * {32'b0, mr2_r};
  assign p_re_full = {32'b0, mr2_r} * {32'b0, ue2_r};
  assign opp_full  = {16'b0, p_as3_r} * {47'b0, mstk3_r};

  always_ff @(posedge clk) begin
    mode1_r  <= in_mode;
    r1_r     <= in_current_rate;
    stk1_r   <= in_stick;
    e1_r     <= in_angle_error;
    step1_r  <= in_step_time;

    mode2_r  <= mode1_r;
    r2_r     <= r1_r;
    stk2_r   <= stk1_r;
    step2_r  <= step1_r;
    mstk2_r  <= stk1_r[15] ? 16'(-stk1_r) : 16'(stk1_r);
    mr2_r    <= r1_r[31] ? 32'(-r1_r) : 32'(r1_r);
    ue2_r    <= e1_r[31] ? 32'(-e1_r) : 32'(e1_r);
    epos2_r  <= !e1_r[31] && (e1_r != 32'sd0);
    ezero2_r <= (e1_r == 32'sd0);

    mode3_r  <= mode2_r;
    r3_r     <= r2_r;
    epos3_r  <= epos2_r;
    ezero3_r <= ezero2_r;
    mstk3_r  <= mstk2_r;
    ue3_r    <= ue2_r;
    p_rr3_r  <= p_rr_full;
    p_re3_r  <= p_re_full[62:0];
    p_as3_r  <= 47'(accel_r) * 47'(step2_r);
    p_t3_r   <= 47'(stk2_r) * 47'(lim_s);

    mode4_r  <= mode3_r;
    r4_r     <= r3_r;
    epos4_r  <= epos3_r;
    ezero4_r <= ezero3_r;
    ue4_r    <= ue3_r;
    p_rr4_r  <= p_rr3_r;
    p_re4_r  <= p_re3_r;
    full4_r  <= p_as3_r[46:16];
    opp4_r   <= opp_full[62:31];
    sue4_r   <= 63'(p_as3_r[46:16]) * 63'(ue3_r);
    t4_r     <= 33'($signed(p_t3_r[46:15]));
    fall4_r  <= (ue3_r < {1'b0, falloff_r});

    p_rr5_r      <= p_rr4_r;
    sd1_r.mode   <= mode4_r;
    sd1_r.n0     <= n0_nxt;
    sd1_r.r      <= r4_r;
    sd1_r.epos   <= epos4_r;
    sd1_r.ezero  <= ezero4_r;
    sd1_r.ue     <= ue4_r;
    sd1_r.p_re   <= p_re4_r;
    sd1_r.full   <= full4_r;
    sd1_r.sue    <= sue4_r;
    sd1_r.fall   <= fall4_r;
    sd1_r.a_zero <= (accel_r == '0);
  end

  // stick command: slew toward target, never past it or past the limit
  always_comb begin
    logic signed [34:0] rx, tx, limx, slew, n;
    rx   = 35'(r4_r);
    tx   = 35'(t4_r);
    limx = 35'({1'b0, max_rate_r});
    n    = rx;
    if (rx > tx) begin
      slew = r4_r[31] ? 35'(opp4_r) : 35'(full4_r);
      n    = rx - slew;
      if (n < tx) n = tx;
      else if (n > limx) n = limx;
    end else if (rx < tx) begin
      slew = (r4_r > 32'sd0) ? 35'(opp4_r) : 35'(full4_r);
      n    = rx + slew;
      if (n > tx) n = tx;
      else if (n < -limx) n = -limx;
    end else begin
      slew = '0;
    end
    n0_nxt = n[31:0];
  end

  // deceleration distance: r^2 / (2 * accel)
  logic                      d1_vld;
  logic [61:0]               d1_quo;
  logic [$bits(side1_t)-1:0] d1_side_bits;
  side1_t                    d1_side;

  arp_div_pipe #(
    .NUM_W  (64),
    .DEN_W  (32),
    .QUO_W  (62),
    .SIDE_W ($bits(side1_t))
  ) u_div_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_num   (p_rr5_r),
    .in_den   ({accel_r, 1'b0}),
    .in_side  (sd1_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side_bits)
  );

  assign d1_side = d1_side_bits;

  // stage 6: pick the ratio to divide
  logic        v6_r;
  logic [62:0] num6_r;
  logic [63:0] den6_r;
  side2_t      sd2_r;
  logic [63:0] decel_dist;
  logic        near;

  assign decel_dist = d1_side.a_zero ? '1 : {2'b0, d1_quo};
  assign near       = ({32'b0, d1_side.ue} < decel_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    num6_r      <= near ? d1_side.p_re : d1_side.sue;
    den6_r      <= near ? decel_dist : {33'b0, falloff_r};
    sd2_r.mode  <= d1_side.mode;
    sd2_r.n0    <= d1_side.n0;
    sd2_r.r     <= d1_side.r;
    sd2_r.epos  <= d1_side.epos;
    sd2_r.ezero <= d1_side.ezero;
    sd2_r.near  <= near;
    sd2_r.fall  <= d1_side.fall;
    sd2_r.full  <= d1_side.full;
  end

  // proportional rate or falloff slew
  logic                      d2_vld;
  logic [31:0]               d2_quo;
  logic [$bits(side2_t)-1:0] d2_side_bits;
  side2_t                    d2_side;

  arp_div_pipe #(
    .NUM_W  (63),
    .DEN_W  (64),
    .QUO_W  (32),
    .SIDE_W ($bits(side2_t))
  ) u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v6_r),
    .in_num   (num6_r),
    .in_den   (den6_r),
    .in_side  (sd2_r),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side_bits)
  );

  assign d2_side = d2_side_bits;

  // stage 7: pointing result and output select
  logic signed [31:0] new_rate_nxt;

  always_comb begin
    logic signed [33:0] rr, lim, s, n;
    rr  = 34'($signed(d2_side.r));
    lim = 34'({1'b0, max_rate_r});
    s   = d2_side.fall ? 34'(d2_quo) : 34'(d2_side.full);
    n   = rr;
    if (d2_side.ezero) begin
      n = rr;
    end else if (d2_side.near) begin
      n = rr[33] ? -34'(d2_quo) : 34'(d2_quo);
    end else if (d2_side.epos) begin
      if (rr > -lim) n = rr - s;
      if (n < -lim) n = -lim;
    end else begin
      if (rr < lim) n = rr + s;
      if (n > lim) n = lim;
    end
    new_rate_nxt = d2_side.mode ? n[31:0] : $signed(d2_side.n0);
  end

  logic               out_strobe_r;
  logic signed [31:0] out_new_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_new_rate_r <= new_rate_nxt;
  end

  assign out_strobe   = out_strobe_r;
  assign out_new_rate = out_new_rate_r;

  // every result strobe traces back to an accepted transaction
  a_strobe_has_txn: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 101))
    else $error("result strobe without a matching transaction");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // when the rate is above target, the stick slew lands between target and current rate
  a_stick_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && (33'(r4_r) > t4_r) |=>
      (33'($signed(sd1_r.n0)) <= 33'($signed($past(r4_r)))) &&
      (33'($signed(sd1_r.n0)) >= $past(t4_r)))
    else $error("stick slew left the target to rate window");

  // ratio and falloff quotients fit in 31 bits
  a_ratio_fits: assert property (@(posedge clk) disable iff (!rst_n)
    d2_vld && (d2_side.near || d2_side.fall) |-> !d2_quo[31])
    else $error("ratio quotient overflow");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the axis rate profiler: directed and random ticks checked against a rate predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb import arp_pkg::*;;

  localparam int LATENCY = 101;
  localparam longint LIMIT_CYCLES = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_mode;
  logic signed [31:0] in_current_rate;
  logic signed [15:0] in_stick;
  logic signed [31:0] in_angle_error;
  logic [15:0] in_step_time;
  logic out_strobe;
  logic signed [31:0] out_new_rate;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  logic [30:0] accel_q, max_q, falloff_q;
  logic signed [31:0] rate_expected[$];
  int fail_count = 0;
  int sent_count;
  int checked_count = 0;
  longint cycle_count = 0;

  axis_rate_profiler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_current_rate(in_current_rate), .in_stick(in_stick),
    .in_angle_error(in_angle_error), .in_step_time(in_step_time),
    .out_strobe(out_strobe), .out_new_rate(out_new_rate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("axis_rate_profiler: mismatch");
      $finish;
    end
  end

  function automatic longint floor_div_pow2(longint x, int n);
    if (x >= 0) return x >>> n;
    return -((~x) >>> n) - 1;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [31:0] predict_rate(logic mode, logic signed [31:0] rate,
      logic signed [15:0] stick, logic signed [31:0] err, logic [15:0] step);
    longint r, lim, t, n, stk, e;
    longint unsigned prod, full, opp, mr, ue, decel_dist, s, q;
    r = rate;
    stk = stick;
    e = err;
    lim = max_q;
    n = r;
    prod = longint'(accel_q) * step;
    if (!mode) begin
      t = floor_div_pow2(stk * lim, 15);
      full = prod >> 16;
      opp = (prod * magnitude(stk)) >> 31;
      if (r > t) begin
        n = r - longint'(r < 0 ? opp : full);
        if (n < t) n = t;
        else if (n > lim) n = lim;
      end else if (r < t) begin
        n = r + longint'(r > 0 ? opp : full);
        if (n > t) n = t;
        else if (n < -lim) n = -lim;
      end
      return n[31:0];
    end
    if (e == 0) return rate;
    mr = magnitude(r);
    ue = magnitude(e);
    decel_dist = (accel_q != 0) ? (mr * mr) / (2 * longint'(accel_q))
                                : 64'hFFFF_FFFF_FFFF_FFFF;
    if (ue < decel_dist) begin
      q = (mr * ue) / decel_dist;
      n = (r < 0) ? -longint'(q) : longint'(q);
      return n[31:0];
    end
    s = prod >> 16;
    if (ue < falloff_q) s = (s * ue) / falloff_q;
    if (e > 0) begin
      if (r > -lim) n = r - longint'(s);
      if (n < -lim) n = -lim;
    end else begin
      if (r < lim) n = r + longint'(s);
      if (n > lim) n = lim;
    end
    return n[31:0];
  endfunction

  // Check every result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (rate_expected.size() == 0) begin
        $error("new_rate: unexpected result %0d", out_new_rate);
        fail_count++;
      end else begin
        if (out_new_rate !== rate_expected[0]) begin
          $error("new_rate: expected %0d, actual %0d", rate_expected[0], out_new_rate);
          fail_count++;
        end
        void'(rate_expected.pop_front());
        checked_count++;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_tick(logic mode, logic signed [31:0] rate, logic signed [15:0] stick,
      logic signed [31:0] err, logic [15:0] step, bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    in_mode <= mode;
    in_current_rate <= rate;
    in_stick <= stick;
    in_angle_error <= err;
    in_step_time <= step;
    @(posedge clk);
    while (busy) @(posedge clk);
    rate_expected.push_back(predict_rate(mode, rate, stick, err, step));
    sent_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rate_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_ACCEL: accel_q = value;
      CFG_MAX_RATE: max_q = value;
      default: falloff_q = value;
    endcase
  endtask

  task automatic set_regs(logic [30:0] a, logic [30:0] m, logic [30:0] f);
    drain();
    write_reg(CFG_ACCEL, a);
    write_reg(CFG_MAX_RATE, m);
    write_reg(CFG_FALLOFF, f);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    // Defaults after reset.
    send_tick(1'b0, 32'sd0, 16'sh7FFF, 32'sd0, 16'hFFFF, 1'b0);
    send_tick(1'b0, 32'sd100000, 16'sh8000, 32'sd0, 16'd655, 1'b0);
    send_tick(1'b0, 32'sd5898240, 16'sh7FFF, 32'sd0, 16'd655, 1'b0);
    send_tick(1'b0, -32'sd200000, 16'sh4000, 32'sd0, 16'd1000, 1'b0);
    send_tick(1'b0, 32'sh7FFF_FFFF, 16'sd0, 32'sd0, 16'hFFFF, 1'b0);
    send_tick(1'b0, 32'sh8000_0000, 16'sd0, 32'sd0, 16'hFFFF, 1'b0);
    send_tick(1'b1, 32'sd1000, 16'sd0, 32'sd0, 16'd500, 1'b0);
    send_tick(1'b1, 32'sd3000000, 16'sd0, 32'sd100, 16'd500, 1'b0);
    send_tick(1'b1, -32'sd3000000, 16'sd0, -32'sd100, 16'd500, 1'b0);
    send_tick(1'b1, 32'sd0, 16'sd0, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    send_tick(1'b1, 32'sd0, 16'sd0, 32'sh8000_0000, 16'hFFFF, 1'b0);
    send_tick(1'b1, 32'sh8000_0000, 16'sd0, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    send_tick(1'b1, 32'sh7FFF_FFFF, 16'sd0, -32'sd1, 16'd0, 1'b0);
    // Zero acceleration: distance saturates.
    set_regs(31'd0, 31'h7FFF_FFFF, 31'd0);
    send_tick(1'b1, 32'sd123456, 16'sd0, 32'sd1, 16'd100, 1'b0);
    send_tick(1'b0, 32'sd0, 16'sh7FFF, 32'sd0, 16'hFFFF, 1'b0);
    // Falloff and extreme limits.
    set_regs(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
    send_tick(1'b1, 32'sd0, 16'sd0, 32'sd65536, 16'hFFFF, 1'b0);
    send_tick(1'b1, 32'sd10, 16'sd0, -32'sd65536, 16'hFFFF, 1'b0);
    send_tick(1'b0, 32'sd10, 16'sh7FFF, 32'sd0, 16'hFFFF, 1'b0);
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1000000);
    send_tick(1'b1, -32'sd5, 16'sd0, 32'sd200000, 16'd3000, 1'b0);
    send_tick(1'b0, 32'sd4000000, 16'shC000, 32'sd0, 16'd20, 1'b0);
    send_tick(1'b0, -32'sd4000000, 16'sh3000, 32'sd0, 16'd20, 1'b0);
  endtask

  function automatic logic signed [31:0] rand_value32();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 20000000)) - 32'sd10000000;
      2: return $signed($urandom_range(0, 2000)) - 32'sd1000;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic test_random();
    logic [30:0] a, m, f;
    for (int phase = 0; phase < 8; phase++) begin
      a = $urandom_range(0, 1) ? 31'($urandom_range(1, 50000000)) : 31'($urandom());
      m = $urandom_range(0, 1) ? 31'($urandom_range(0, 20000000)) : 31'($urandom());
      f = ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom_range(1, 5000000));
      if (phase == 7) m = 31'h7FFF_FFFF;
      set_regs(a, m, f);
      for (int i = 0; i < 48; i++)
        send_tick(1'($urandom_range(0, 1)), rand_value32(), 16'($urandom()), rand_value32(),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000)),
                  1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_current_rate = '0;
    in_stick = '0;
    in_angle_error = '0;
    in_step_time = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACCEL;
    cfg_data = '0;
    accel_q = ACCEL_RST;
    max_q = MAX_RATE_RST;
    falloff_q = FALLOFF_RST;
    sent_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("sent %0d ticks in both modes over several register settings", sent_count);
    $display("checked %0d rate results", checked_count);
    if (fail_count == 0 && rate_expected.size() == 0) begin
      $display("axis_rate_profiler: match");
    end else begin
      $display("axis_rate_profiler: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
